>>> src/ccr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types, constants and the CRC byte update for the config reassembler.
// ----------------------------------------------------------------------------
package ccr_pkg;

	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned ADDR_W      = 10;
	localparam int unsigned LEN_W       = 11;
	localparam int unsigned HEADER_LEN  = 11;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  MAGIC_0  = 8'h53; // 'S'
	localparam logic [7:0]  MAGIC_1  = 8'h33; // '3'
	localparam logic [7:0]  MAGIC_2  = 8'h43; // 'C'
	localparam logic [7:0]  VERSION  = 8'd1;

	typedef enum logic [2:0] {
		ST_PENDING   = 3'd0,
		ST_COMPLETE  = 3'd1,
		ST_INVALID   = 3'd2,
		ST_MALFORMED = 3'd3,
		ST_ORDER     = 3'd4,
		ST_CRC       = 3'd5
	} status_t;

	typedef enum logic {
		REQ_REPORT = 1'b0,
		REQ_READ   = 1'b1
	} req_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	// CRC-16-CCITT, MSB first, eight bit steps unrolled
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> src/chunked_config_reassembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_config_reassembler_unit
// Strips the report id, parses the chunk header, stages chunk bytes straight
// into payload memory and commits them at end of report; serves index reads.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  input   | in_valid/in_ready, req_type, data_byte,          | in
//          | end_of_report, epoch, read_index                 |
//  result  | out_valid/out_ready, result_kind, status,        | out
//          | payload_length, read_data                        |
//  config  | cfg_we, cfg_wdata (report_id)                    | in
//
// One transaction per cycle on the input while in_ready is high; a result
// passes the s1 stage (waiting on the synchronous payload memory read) and
// the output register. The s1 stage and the output register let one further
// transaction in while a result waits. Reset leaves both memories unwritten;
// no clearing pass is needed since reads are masked by the committed length.
// ----------------------------------------------------------------------------
module chunked_config_reassembler_unit #(
	parameter int unsigned MAX_CHUNK_DATA = 53
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        end_of_report,
	input  logic [31:0] epoch,
	input  logic [9:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [2:0]  status,
	output logic [10:0] payload_length,
	output logic [7:0]  read_data
);

	localparam int unsigned CW     = (MAX_CHUNK_DATA > 1) ? $clog2(MAX_CHUNK_DATA) : 1;
	localparam int unsigned FDEPTH = 2 << CW;
	localparam int unsigned LW     = ccr_pkg::LEN_W;
	localparam int unsigned AW     = ccr_pkg::ADDR_W;

	// memories: main store by absolute position, ping-pong banks for chunk 0
	logic [7:0] main_mem [ccr_pkg::MAX_PAYLOAD];
	logic [7:0] first_mem [FDEPTH];
	logic [7:0] main_rd_q, first_rd_q;

	logic [7:0]  report_id_q;
	logic [7:0]  hdr_q [ccr_pkg::HEADER_LEN];
	logic [7:0]  rbc_q, seen_q;
	logic        pfx_q, ebad_q;
	logic [LW-1:0] exp_tot_q, clen_q;
	logic [15:0] exp_chk_q, ccrc_q, kcrc_q;
	logic [7:0]  exp_cnt_q, nxt_q;
	logic [31:0] cur_epoch_q;
	logic        bank_q;
	logic [7:0]  first_len_q;

	logic              valid_s1, kind_s1, inr_s1, first_s1;
	ccr_pkg::status_t  status_s1;
	logic [LW-1:0]     len_s1;
	logic              out_valid_q, kind_q;
	logic [2:0]        status_q;
	logic [LW-1:0]     len_q;
	logic [7:0]        rdata_q;

	logic s1_adv, acc, acc_rd, acc_rep;
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign acc      = in_valid && in_ready;
	assign acc_rd   = acc && (req_type == ccr_pkg::REQ_READ);
	assign acc_rep  = acc && (req_type == ccr_pkg::REQ_REPORT);

	// next-state of the report logic
	logic [7:0]  hdr_n [ccr_pkg::HEADER_LEN];
	logic [7:0]  rbc_n, seen_n, seen_c, rbc_c;
	logic        pfx_n, ebad_n, ebad_c, first_byte, strip, clr;
	logic [LW-1:0] exp_tot_n, clen_n;
	logic [15:0] exp_chk_n, ccrc_n, kcrc_n;
	logic [7:0]  exp_cnt_n, nxt_n, first_len_n;
	logic        bank_n, fin, wr_main, wr_first;
	logic [AW:0] wsum;
	ccr_pkg::status_t st_c;
	logic [7:0]  h_idx, h_cnt, h_clen;
	logic [15:0] h_tot, h_chk;
	logic [LW:0] csum;

	always_comb begin
		hdr_n       = hdr_q;
		rbc_n       = rbc_q;
		seen_n      = seen_q;
		pfx_n       = pfx_q;
		ebad_n      = ebad_q;
		exp_tot_n   = exp_tot_q;
		exp_chk_n   = exp_chk_q;
		exp_cnt_n   = exp_cnt_q;
		nxt_n       = nxt_q;
		clen_n      = clen_q;
		ccrc_n      = ccrc_q;
		kcrc_n      = kcrc_q;
		bank_n      = bank_q;
		first_len_n = first_len_q;
		st_c        = ccr_pkg::ST_PENDING;
		fin         = 1'b0;
		wr_main     = 1'b0;
		wr_first    = 1'b0;
		seen_c      = seen_q;
		rbc_c       = rbc_q;
		ebad_c      = ebad_q;
		first_byte  = (rbc_q == 8'd0) && !pfx_q;
		clr         = first_byte && (epoch != 32'd0) && (epoch != cur_epoch_q);
		strip       = first_byte && !end_of_report && (data_byte == report_id_q);
		wsum        = {1'b0, clen_q[AW-1:0]} + {{(AW-7){1'b0}}, seen_q};
		if (first_byte) begin
			ebad_c = (epoch == 32'd0);
		end
		if (clr) begin
			exp_tot_n = '0;
			exp_chk_n = '0;
			exp_cnt_n = '0;
			nxt_n     = '0;
			clen_n    = '0;
			ccrc_n    = ccr_pkg::CRC_INIT;
			kcrc_n    = ccr_pkg::CRC_INIT;
		end
		if (!strip) begin
			if (rbc_q < 8'(ccr_pkg::HEADER_LEN)) begin
				hdr_n[rbc_q[3:0]] = data_byte;
				if (rbc_q == 8'(ccr_pkg::HEADER_LEN - 1)) begin
					kcrc_n = (hdr_n[4] == 8'd0) ? ccr_pkg::CRC_INIT : ccrc_n;
				end
			end else begin
				if ((seen_q < hdr_q[8]) && (seen_q < 8'(MAX_CHUNK_DATA))) begin
					kcrc_n = ccr_pkg::crc_byte(kcrc_n, data_byte);
					// chunk 0 goes to the idle bank, later chunks past the commit point
					if (hdr_q[4] == 8'd0) begin
						wr_first = 1'b1;
					end else begin
						wr_main = (wsum < (AW+1)'(ccr_pkg::MAX_PAYLOAD)) &&
							(clen_q < LW'(ccr_pkg::MAX_PAYLOAD));
					end
				end
				if (seen_q != 8'hFF) seen_c = seen_q + 8'd1;
			end
			if (rbc_q != 8'hFF) rbc_c = rbc_q + 8'd1;
		end
		h_idx  = hdr_n[4];
		h_cnt  = hdr_n[5];
		h_tot  = {hdr_n[7], hdr_n[6]};
		h_clen = hdr_n[8];
		h_chk  = {hdr_n[10], hdr_n[9]};
		csum   = '0;
		if (!strip && end_of_report) begin
			fin = 1'b1;
			if (ebad_c || (rbc_c < 8'(ccr_pkg::HEADER_LEN)) ||
				(hdr_n[0] != ccr_pkg::MAGIC_0) || (hdr_n[1] != ccr_pkg::MAGIC_1) ||
				(hdr_n[2] != ccr_pkg::MAGIC_2) || (hdr_n[3] != ccr_pkg::VERSION)) begin
				st_c = ccr_pkg::ST_INVALID;
			end else if ((h_cnt == 8'd0) || (h_idx >= h_cnt) || (h_tot == 16'd0) ||
				(h_tot > 16'(ccr_pkg::MAX_PAYLOAD)) || (h_clen > 8'(MAX_CHUNK_DATA)) ||
				(seen_c < h_clen)) begin
				st_c = ccr_pkg::ST_MALFORMED;
			end else begin
				if (h_idx == 8'd0) begin
					exp_tot_n = h_tot[LW-1:0];
					exp_chk_n = h_chk;
					exp_cnt_n = h_cnt;
					nxt_n     = '0;
					clen_n    = '0;
					ccrc_n    = ccr_pkg::CRC_INIT;
				end
				csum = {1'b0, clen_n} + {{(LW-7){1'b0}}, h_clen};
				if ((h_idx != nxt_n) || (h_tot != 16'(exp_tot_n)) || (h_cnt != exp_cnt_n) ||
					(h_chk != exp_chk_n) || (csum > {1'b0, exp_tot_n})) begin
					st_c = ccr_pkg::ST_ORDER;
				end else begin
					clen_n = csum[LW-1:0];
					ccrc_n = kcrc_n;
					nxt_n  = nxt_n + 8'd1;
					if (h_idx == 8'd0) begin
						bank_n      = !bank_q;
						first_len_n = h_clen;
					end
					if (nxt_n < exp_cnt_n) begin
						st_c = ccr_pkg::ST_PENDING;
					end else if ((clen_n != exp_tot_n) || (ccrc_n != exp_chk_n)) begin
						st_c = ccr_pkg::ST_CRC;
					end else begin
						st_c = ccr_pkg::ST_COMPLETE;
					end
				end
			end
		end
		if (strip) begin
			pfx_n = 1'b1;
			ebad_n = ebad_c;
		end else if (fin) begin
			for (int i = 0; i < ccr_pkg::HEADER_LEN; i++) hdr_n[i] = 8'd0;
			rbc_n  = '0;
			seen_n = '0;
			pfx_n  = 1'b0;
			ebad_n = 1'b0;
		end else begin
			rbc_n  = rbc_c;
			seen_n = seen_c;
			ebad_n = ebad_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_id_q <= '0;
			for (int i = 0; i < ccr_pkg::HEADER_LEN; i++) hdr_q[i] <= '0;
			rbc_q       <= '0;
			seen_q      <= '0;
			pfx_q       <= 1'b0;
			ebad_q      <= 1'b0;
			exp_tot_q   <= '0;
			exp_chk_q   <= '0;
			exp_cnt_q   <= '0;
			nxt_q       <= '0;
			clen_q      <= '0;
			ccrc_q      <= ccr_pkg::CRC_INIT;
			kcrc_q      <= ccr_pkg::CRC_INIT;
			cur_epoch_q <= '0;
			bank_q      <= 1'b0;
			first_len_q <= '0;
		end else begin
			if (cfg_we) report_id_q <= cfg_wdata;
			if (acc_rep) begin
				hdr_q       <= hdr_n;
				rbc_q       <= rbc_n;
				seen_q      <= seen_n;
				pfx_q       <= pfx_n;
				ebad_q      <= ebad_n;
				exp_tot_q   <= exp_tot_n;
				exp_chk_q   <= exp_chk_n;
				exp_cnt_q   <= exp_cnt_n;
				nxt_q       <= nxt_n;
				clen_q      <= clen_n;
				ccrc_q      <= ccrc_n;
				kcrc_q      <= kcrc_n;
				bank_q      <= bank_n;
				first_len_q <= first_len_n;
				if (clr) cur_epoch_q <= epoch;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rep && wr_main) main_mem[wsum[AW-1:0]] <= data_byte;
		if (acc_rep && wr_first) first_mem[{!bank_q, seen_q[CW-1:0]}] <= data_byte;
		if (acc_rd) begin
			main_rd_q  <= main_mem[read_index];
			first_rd_q <= first_mem[{bank_q, read_index[CW-1:0]}];
		end
	end

	// s1: waits on the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= acc_rd || (acc_rep && fin);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1   <= acc_rd;
			status_s1 <= acc_rd ? ccr_pkg::ST_PENDING : st_c;
			len_s1    <= acc_rd ? clen_q : clen_n;
			inr_s1    <= {1'b0, read_index} < clen_q;
			first_s1  <= {1'b0, read_index} < {3'b0, first_len_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			kind_q   <= kind_s1;
			status_q <= status_s1;
			len_q    <= len_s1;
			if (kind_s1 && inr_s1) begin
				rdata_q <= first_s1 ? first_rd_q : main_rd_q;
			end else begin
				rdata_q <= 8'd0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign status         = status_q;
	assign payload_length = len_q;
	assign read_data      = rdata_q;

endmodule

>>> src/ccr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_checker
// Port-level checks on the result channel of the config reassembler.
// ----------------------------------------------------------------------------
module ccr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic [2:0]  status,
	input logic [10:0] payload_length,
	input logic [7:0]  read_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_data))
		else $error("result changed while stalled");

	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == ccr_pkg::KIND_READ) |-> status == ccr_pkg::ST_PENDING)
		else $error("read result with nonzero status");

	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == ccr_pkg::KIND_STATUS) |-> read_data == 8'd0)
		else $error("status result with read data");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> payload_length <= 11'(ccr_pkg::MAX_PAYLOAD))
		else $error("committed length beyond store");

endmodule

bind chunked_config_reassembler_unit ccr_checker u_ccr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.result_kind(result_kind),
	.status(status),
	.payload_length(payload_length),
	.read_data(read_data)
);
